// File: rtl/lru_page_replacement_core_defines.svh
// ----------------------------------------------------------------------------
// lru_page_replacement_core_defines
// assertion macros for the lru page replacement core
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_CORE_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LRU_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lru check failed");
`define LRU_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lru check failed");
`else
`define LRU_ASSERT_IMPL(label, clk, rst, pre, post)
`define LRU_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// File: rtl/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// shared types for the lru page replacement core
// ----------------------------------------------------------------------------
package lru_pkg;
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } state_type;

   localparam int unsigned OUT_PAGE_BITS  = 16;
   localparam int unsigned OUT_FRAME_BITS = 3;
   localparam logic [15:0] FAULT_MAX      = 16'hFFFF;
endpackage

// File: rtl/lru_frame_store.sv
// ----------------------------------------------------------------------------
// lru_frame_store
// frame page memory, one write port and a registered read of every entry
// ----------------------------------------------------------------------------
module lru_frame_store #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(FRAMES)-1:0]     wr_addr,
   input  logic [PAGE_BITS-1:0]          wr_data,
   output logic [FRAMES*PAGE_BITS-1:0]   rd_data
);
   logic [PAGE_BITS-1:0] mem [FRAMES];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end
   // every entry is read at its own place, registered
   always_ff @(posedge clock) begin
      for (int i = 0; i < FRAMES; i++) begin
         rd_data[i*PAGE_BITS +: PAGE_BITS] <= mem[i];
      end
   end
endmodule

// File: rtl/lru_recency.sv
// ----------------------------------------------------------------------------
// lru_recency
// age counters per frame; the frame with the largest age is the victim
// ----------------------------------------------------------------------------
module lru_recency #(
   parameter int FRAMES = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        touch,
   input  logic [$clog2(FRAMES)-1:0]   touch_frame,
   output logic [$clog2(FRAMES)-1:0]   victim
);
   localparam int FW = $clog2(FRAMES);
   logic [FW-1:0] age_ff [FRAMES];
   logic [FW-1:0] victim_ff, victim_in;

   // ages form a permutation from reset on; largest age is least recent
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) age_ff[i] <= FW'(FRAMES - 1 - i);
      end else if (touch) begin
         for (int i = 0; i < FRAMES; i++) begin
            if (FW'(i) == touch_frame) age_ff[i] <= '0;
            else if (age_ff[i] < age_ff[touch_frame]) age_ff[i] <= age_ff[i] + 1'b1;
         end
      end
   end

   always_comb begin
      victim_in = '0;
      for (int i = 0; i < FRAMES; i++) begin
         if (age_ff[i] == FW'(FRAMES - 1)) victim_in = FW'(i);
      end
   end

   always_ff @(posedge clock) begin
      victim_ff <= victim_in;
   end
   assign victim = victim_ff;
endmodule

// File: rtl/lru_page_replacement_core.sv
// result: the strobe is registered after the read and update states
// a new reference is taken only when idle, after the frame memory read
//   and the recency update of the last one have finished
// reset: synchronous; all frames empty, fault count zero, no result pending
// results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// fully associative lru page replacement over a small set of frames
// ----------------------------------------------------------------------------
`include "lru_page_replacement_core_defines.svh"
module lru_page_replacement_core
   import lru_pkg::*;
#(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_page_number,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [2:0]  rsp_frame_index,
   output logic        rsp_evicted_valid,
   output logic [15:0] rsp_evicted_page,
   output logic [15:0] rsp_fault_count
);
   localparam int FW = $clog2(FRAMES);

   state_type state_ff, state_in;
   logic [PAGE_BITS-1:0]        page_ff;
   logic [FRAMES-1:0]           valid_ff;
   logic [15:0]                 faults_ff;
   logic [FRAMES*PAGE_BITS-1:0] rd_data;
   logic [FW-1:0]               victim;

   // lookup on the registered memory snapshot
   logic          hit_c, blank_c;
   logic [FW-1:0] hit_idx, blank_idx, frame_c;
   logic [PAGE_BITS-1:0] ev_page_c;
   logic          update;

   always_comb begin
      hit_c = 1'b0; hit_idx = '0; blank_c = 1'b0; blank_idx = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (valid_ff[i] && rd_data[i*PAGE_BITS +: PAGE_BITS] == page_ff) begin
            hit_c = 1'b1; hit_idx = FW'(i);
         end
         if (!valid_ff[i]) begin
            blank_c = 1'b1; blank_idx = FW'(i);
         end
      end
      frame_c   = hit_c ? hit_idx : (blank_c ? blank_idx : victim);
      ev_page_c = rd_data[victim*PAGE_BITS +: PAGE_BITS];
   end

   // fsm: idle, wait for memory read, then update and respond
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      update   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_READ;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: begin
            update   = 1'b1;
            state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end
   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) page_ff <= PAGE_BITS'(req_page_number);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         faults_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= update;
         if (update && !hit_c) begin
            valid_ff[frame_c] <= 1'b1;
            if (faults_ff != FAULT_MAX) faults_ff <= faults_ff + 16'd1;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (update) begin
         rsp_hit           <= hit_c;
         rsp_frame_index   <= OUT_FRAME_BITS'(frame_c);
         rsp_evicted_valid <= !hit_c && !blank_c;
         rsp_evicted_page  <= (!hit_c && !blank_c) ? OUT_PAGE_BITS'(ev_page_c) : '0;
         rsp_fault_count   <= (!hit_c && faults_ff != FAULT_MAX) ? faults_ff + 16'd1
                                                                 : faults_ff;
      end
   end

   lru_frame_store #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS)) u_store (
      .clock   (clock),
      .wr_en   (update && !hit_c),
      .wr_addr (frame_c),
      .wr_data (page_ff),
      .rd_data (rd_data)
   );

   lru_recency #(.FRAMES(FRAMES)) u_recency (
      .clock       (clock),
      .reset       (reset),
      .touch       (update),
      .touch_frame (frame_c),
      .victim      (victim)
   );

   // a result follows every update step
   `LRU_ASSERT_NEXT(a_rsp_after_update, clock, reset, update, rsp_valid)
   // busy is high in the read state
   `LRU_ASSERT_IMPL(a_no_start_overlap, clock, reset, state_ff == ST_READ, busy)
   // fault count never drops
   `LRU_ASSERT_NEXT(a_faults_mono, clock, reset, 1'b1, faults_ff >= $past(faults_ff))
endmodule

// File: sim/lru_page_replacement_core_tb.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_core_tb
// self-checking bench for the lru page replacement core: page references are
// driven in random bursts, each accepted transaction is run through a
// behavioural lru model and every result strobe is compared field by field
// ----------------------------------------------------------------------------
module lru_page_replacement_core_tb;
   import lru_pkg::*;

   localparam int NFRAMES = 8;

   typedef struct packed {
      logic        hit;
      logic [2:0]  frame_index;
      logic        evicted_valid;
      logic [15:0] evicted_page;
      logic [15:0] fault_count;
   } page_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [15:0] req_page_number = '0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_hit;
   logic [2:0]  rsp_frame_index;
   logic        rsp_evicted_valid;
   logic [15:0] rsp_evicted_page;
   logic [15:0] rsp_fault_count;

   // stimulus and expectations
   logic [15:0]      page_ref_q[$];
   page_outcome_type expected_outcome_q[$];

   // shadow copy of the frame table and recency list
   logic [15:0] shadow_page[NFRAMES];
   logic        shadow_valid[NFRAMES];
   logic [2:0]  shadow_order[NFRAMES];
   int          shadow_len;
   logic [15:0] shadow_faults;

   int mismatches = 0;
   int checked    = 0;
   int hits_seen  = 0;
   int evicts_seen = 0;
   int saturated_seen = 0;

   // sender burst control
   int burst_left = 0;
   int gap_left   = 0;

   lru_page_replacement_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // look up one reference and update the shadow state, lowest frame wins
   task automatic lru_lookup(input logic [15:0] pg);
      page_outcome_type o;
      int               f;
      int               p;
      bit               found;
      o     = '0;
      f     = 0;
      found = 0;
      for (int i = 0; i < NFRAMES; i++) begin
         if (!found && shadow_valid[i] && shadow_page[i] == pg) begin
            f     = i;
            found = 1;
         end
      end
      o.hit = found;
      if (!found) begin
         bit blank;
         blank = 0;
         for (int i = 0; i < NFRAMES; i++) begin
            if (!blank && !shadow_valid[i]) begin
               f     = i;
               blank = 1;
            end
         end
         if (!blank) begin
            // every frame full: the tail of the recency list is the victim
            if (shadow_len > 0) f = shadow_order[shadow_len-1];
            else f = 0;
            o.evicted_valid = 1'b1;
            o.evicted_page  = shadow_page[f];
         end
         shadow_page[f]  = pg;
         shadow_valid[f] = 1'b1;
         if (shadow_faults != FAULT_MAX) shadow_faults = shadow_faults + 16'd1;
      end
      // move frame to the head of the recency list
      p = 0;
      while (p < shadow_len && shadow_order[p] != f[2:0]) p++;
      if (p == shadow_len) begin
         if (shadow_len < NFRAMES) shadow_len++;
         else p = NFRAMES - 1;
      end
      while (p > 0) begin
         shadow_order[p] = shadow_order[p-1];
         p--;
      end
      shadow_order[0] = f[2:0];
      o.frame_index = f[2:0];
      o.fault_count = shadow_faults;
      expected_outcome_q.push_back(o);
   endtask

   // driver: start is held while a burst lasts, dropped when it ends
   always @(posedge clock) begin
      if (reset) begin
         start           <= 1'b0;
         req_page_number <= '0;
      end else begin
         bit take;
         take = 1'b0;
         if (start && !busy) begin
            // transaction accepted at this edge
            lru_lookup(req_page_number);
            if (burst_left > 0) burst_left--;
            take = (burst_left > 0) && (page_ref_q.size() > 0);
         end else if (start) begin
            take = 1'b1; // still waiting, hold the item
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (page_ref_q.size() > 0) begin
            burst_left = $urandom_range(1, 40);
            take       = 1'b1;
         end
         if (start && !busy && !take) begin
            // burst over, pick a gap; sometimes none
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         end
         if (take && !(start && busy)) begin
            req_page_number <= page_ref_q.pop_front();
            start           <= 1'b1;
         end else if (!take) begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobe must match the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         page_outcome_type got;
         page_outcome_type want;
         got = '{rsp_hit, rsp_frame_index, rsp_evicted_valid, rsp_evicted_page,
                 rsp_fault_count};
         if (expected_outcome_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: hit=%0d frame=%0d ev=%0d/%h faults=%0d",
                        got.hit, got.frame_index, got.evicted_valid,
                        got.evicted_page, got.fault_count);
         end else begin
            want = expected_outcome_q.pop_front();
            checked++;
            if (want.hit) hits_seen++;
            if (want.evicted_valid) evicts_seen++;
            if (want.fault_count == FAULT_MAX) saturated_seen++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch %0d: exp hit=%0d frame=%0d ev=%0d/%h faults=%0d, got hit=%0d frame=%0d ev=%0d/%h faults=%0d",
                           checked, want.hit, want.frame_index, want.evicted_valid,
                           want.evicted_page, want.fault_count, got.hit,
                           got.frame_index, got.evicted_valid, got.evicted_page,
                           got.fault_count);
            end
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      logic [15:0] pool[12];
      int          pool_size;
      for (int i = 0; i < NFRAMES; i++) begin
         shadow_page[i]  = '0;
         shadow_valid[i] = 1'b0;
         shadow_order[i] = '0;
      end
      shadow_len    = 0;
      shadow_faults = '0;

      // directed: fill with extremes, hit, repeat, then evict
      page_ref_q.push_back(16'h0000);
      page_ref_q.push_back(16'hFFFF);
      page_ref_q.push_back(16'h0000);      // hit on frame 0
      page_ref_q.push_back(16'h0000);      // repeated hit
      page_ref_q.push_back(16'h5555);
      page_ref_q.push_back(16'hAAAA);
      page_ref_q.push_back(16'h0001);
      page_ref_q.push_back(16'h8000);
      page_ref_q.push_back(16'h7FFF);
      page_ref_q.push_back(16'h1234);      // last blank frame
      page_ref_q.push_back(16'hFFFF);      // hit, becomes most recent
      page_ref_q.push_back(16'hBEEF);      // evicts lru page
      page_ref_q.push_back(16'hCAFE);
      page_ref_q.push_back(16'h0000);
      page_ref_q.push_back(16'hBEEF);
      page_ref_q.push_back(16'hFFFE);

      // random: working sets with random content plus wide noise
      pool_size = 0;
      for (int n = 0; n < 740; n++) begin
         if (n % 60 == 0) begin
            pool_size = $urandom_range(4, 12);
            foreach (pool[k]) pool[k] = 16'($urandom_range(0, 65535));
         end
         if ($urandom_range(0, 9) < 8) page_ref_q.push_back(pool[$urandom_range(0, pool_size-1)]);
         else page_ref_q.push_back(16'($urandom_range(0, 65535)));
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (page_ref_q.size() > 0 || start || expected_outcome_q.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("checked %0d results: %0d hits, %0d evictions, %0d at saturated count",
               checked, hits_seen, evicts_seen, saturated_seen);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0 && expected_outcome_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #200000;
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
